// ===== design/lbm_pkg.sv =====
package lbm_pkg;

  // Register indexes on the configuration channel
  localparam logic [7:0] REG_BLEND_MODE = 8'd0;
  localparam logic [7:0] REG_MIX_ALPHA  = 8'd1;

  // Blend mode codes
  localparam logic [4:0] MODE_NORMAL       = 5'd0;
  localparam logic [4:0] MODE_LIGHTEN      = 5'd1;
  localparam logic [4:0] MODE_DARKEN       = 5'd2;
  localparam logic [4:0] MODE_MULTIPLY     = 5'd3;
  localparam logic [4:0] MODE_AVERAGE      = 5'd4;
  localparam logic [4:0] MODE_ADD          = 5'd5;
  localparam logic [4:0] MODE_SUBTRACT     = 5'd6;
  localparam logic [4:0] MODE_DIFFERENCE   = 5'd7;
  localparam logic [4:0] MODE_NEGATION     = 5'd8;
  localparam logic [4:0] MODE_SCREEN       = 5'd9;
  localparam logic [4:0] MODE_EXCLUSION    = 5'd10;
  localparam logic [4:0] MODE_OVERLAY      = 5'd11;
  localparam logic [4:0] MODE_SOFT_LIGHT   = 5'd12;
  localparam logic [4:0] MODE_HARD_LIGHT   = 5'd13;
  localparam logic [4:0] MODE_COLOR_DODGE  = 5'd14;
  localparam logic [4:0] MODE_COLOR_BURN   = 5'd15;
  localparam logic [4:0] MODE_LINEAR_DODGE = 5'd16;
  localparam logic [4:0] MODE_LINEAR_BURN  = 5'd17;
  localparam logic [4:0] MODE_LINEAR_LIGHT = 5'd18;
  localparam logic [4:0] MODE_VIVID_LIGHT  = 5'd19;
  localparam logic [4:0] MODE_PIN_LIGHT    = 5'd20;
  localparam logic [4:0] MODE_HARD_MIX     = 5'd21;
  localparam logic [4:0] MODE_REFLECT      = 5'd22;
  localparam logic [4:0] MODE_GLOW         = 5'd23;
  localparam logic [4:0] MODE_PHOENIX      = 5'd24;
  localparam logic [4:0] MODE_DIVIDE       = 5'd25;

  // Full weight of the Q1.8 mix factor
  localparam logic [8:0] ALPHA_ONE = 9'd256;
  // ceil(2^25 / 255): x/255 == (x * RECIP_255) >> 25 for x < 2^17
  localparam logic [17:0] RECIP_255 = 18'd131587;

  // Per-channel working set, carried down the pipeline
  typedef struct packed {
    logic [4:0]  rmode;     // operation actually evaluated
    logic [7:0]  rs;        // first operand
    logic [7:0]  rm;        // second operand
    logic [7:0]  tow;       // value the mix leans toward
    logic        pass;      // output the source unchanged
    logic [7:0]  pass_val;
    logic        hmix;      // threshold after the mix
    logic [16:0] prod;      // product for the /255 and >>8 modes
    logic [15:0] num;       // dividend
    logic [7:0]  den;       // divisor
    logic [7:0]  rem;       // partial remainder
    logic [8:0]  nlo;       // dividend bits still to shift in
    logic [8:0]  quo;       // quotient bits so far
    logic        ovf;       // quotient above 511
    logic [7:0]  raw;       // mode result before the mix
  } ch_t;

  typedef struct packed {
    ch_t [2:0]  ch;
    logic [7:0] alpha;
  } st_t;

  // Operand selection, dividend/divisor and product setup
  function automatic ch_t pre(logic [4:0] mode, logic [7:0] s, logic [7:0] m);
    ch_t        c;
    logic [7:0] m2;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] k;
    logic       dbl;
    logic       add;
    c = '0;
    c.pass_val = s;
    c.rs = s;
    c.rm = m;
    c.tow = m;
    c.rmode = mode;
    m2 = {m[6:0], 1'b0};
    case (mode)
      MODE_NORMAL: begin
        c.rs = m;
        c.rm = s;
        c.tow = s;
        c.pass = (m == 8'd0);
      end
      MODE_HARD_LIGHT: begin
        c.rmode = MODE_OVERLAY;
        c.rs = m;
        c.rm = s;
        c.tow = s;
      end
      MODE_GLOW: begin
        c.rmode = MODE_REFLECT;
        c.rs = m;
        c.rm = s;
        c.tow = s;
      end
      MODE_LINEAR_LIGHT: begin
        c.rmode = m[7] ? MODE_LINEAR_DODGE : MODE_LINEAR_BURN;
        c.rm = m2;
        c.tow = m2;
      end
      MODE_VIVID_LIGHT, MODE_HARD_MIX: begin
        c.rmode = m[7] ? MODE_COLOR_DODGE : MODE_COLOR_BURN;
        c.rm = m2;
        c.tow = m2;
        c.hmix = (mode == MODE_HARD_MIX);
      end
      MODE_PIN_LIGHT: begin
        c.rmode = m[7] ? MODE_LIGHTEN : MODE_DARKEN;
        c.rm = m2;
        c.tow = m2;
      end
      default: c.pass = (mode > MODE_DIVIDE);
    endcase

    // Dividend and divisor
    case (c.rmode)
      MODE_COLOR_DODGE: begin
        c.num = {c.rs, 8'h00};
        c.den = ~c.rm;
      end
      MODE_COLOR_BURN: begin
        c.num = {~c.rs, 8'h00};
        c.den = c.rm;
      end
      MODE_REFLECT: begin
        c.num = 16'(c.rs) * 16'(c.rs);
        c.den = ~c.rm;
      end
      MODE_DIVIDE: begin
        c.num = {c.rs, 8'h00} - {8'h00, c.rs};
        c.den = c.rm;
      end
      default: begin
        c.num = '0;
        c.den = '0;
      end
    endcase

    // One shared 8x8 product
    x = c.rs;
    y = c.rm;
    dbl = 1'b0;
    add = 1'b0;
    k = {1'b0, c.rm[7:1]} + 8'd64;
    case (c.rmode)
      MODE_EXCLUSION: dbl = 1'b1;
      MODE_OVERLAY: begin
        dbl = 1'b1;
        if (c.rm[7]) begin
          x = ~c.rs;
          y = ~c.rm;
        end
      end
      MODE_SOFT_LIGHT: begin
        dbl = 1'b1;
        if (!c.rs[7]) begin
          x = k;
          y = c.rs;
        end else begin
          x = ~k;
          y = ~c.rs;
          add = 1'b1;
        end
      end
      MODE_SCREEN: begin
        x = ~c.rs;
        y = ~c.rm;
      end
      default: dbl = 1'b0;
    endcase
    c.prod = (dbl ? {16'(x) * 16'(y), 1'b0} : {1'b0, 16'(x) * 16'(y)})
             + (add ? 17'd254 : 17'd0);
    return c;
  endfunction

  // Three restoring division steps
  function automatic ch_t div_step3(ch_t c);
    logic [8:0] r9;
    for (int i = 0; i < 3; i++) begin
      r9 = {c.rem, c.nlo[8]};
      c.nlo = {c.nlo[7:0], 1'b0};
      if (r9 >= {1'b0, c.den}) begin
        r9 = r9 - {1'b0, c.den};
        c.quo = {c.quo[7:0], 1'b1};
      end else begin
        c.quo = {c.quo[7:0], 1'b0};
      end
      c.rem = r9[7:0];
    end
    return c;
  endfunction

  // Overflow check, then the first three steps
  function automatic ch_t div_init(ch_t c);
    c.rem = {1'b0, c.num[15:9]};
    c.nlo = c.num[8:0];
    c.ovf = ({1'b0, c.num[15:9]} >= c.den);
    c.quo = '0;
    return div_step3(c);
  endfunction

  // Mode result from operands, product and quotient
  function automatic logic [7:0] raw_result(ch_t c);
    logic [8:0]  sum9;
    logic [8:0]  q;
    logic [34:0] pr;
    logic [8:0]  d;
    logic [8:0]  e9;
    logic [7:0]  dif;
    logic [7:0]  r;
    sum9 = {1'b0, c.rs} + {1'b0, c.rm};
    pr = {18'b0, c.prod} * {17'b0, RECIP_255};
    d = pr[33:25];
    q = c.ovf ? 9'h1FF : c.quo;
    dif = (c.rs >= c.rm) ? c.rs - c.rm : c.rm - c.rs;
    e9 = sum9 - d;
    case (c.rmode)
      MODE_LIGHTEN:    r = (c.rs > c.rm) ? c.rs : c.rm;
      MODE_DARKEN:     r = (c.rs < c.rm) ? c.rs : c.rm;
      MODE_MULTIPLY:   r = d[7:0];
      MODE_AVERAGE:    r = sum9[8:1];
      MODE_ADD, MODE_LINEAR_DODGE:
        r = sum9[8] ? 8'hFF : sum9[7:0];
      MODE_SUBTRACT, MODE_LINEAR_BURN:
        r = (sum9 < 9'd255) ? 8'd0 : 8'(sum9 - 9'd255);
      MODE_DIFFERENCE: r = dif;
      MODE_NEGATION:   r = sum9[8] ? 8'(9'd510 - sum9) : sum9[7:0];
      MODE_SCREEN:     r = 8'hFF - c.prod[15:8];
      MODE_EXCLUSION:  r = e9[7:0];
      MODE_OVERLAY:    r = c.rm[7] ? 8'hFF - d[7:0] : d[7:0];
      MODE_SOFT_LIGHT: r = c.rs[7] ? 8'hFF - d[7:0] : d[7:0];
      MODE_COLOR_DODGE, MODE_REFLECT:
        r = (c.rm == 8'hFF || q[8]) ? 8'hFF : q[7:0];
      MODE_COLOR_BURN:
        r = (c.rm == 8'd0 || q >= 9'd255) ? 8'd0 : 8'(9'd255 - q);
      MODE_PHOENIX:    r = 8'hFF - dif;
      MODE_DIVIDE:     r = (c.rm == 8'd0 || q[8]) ? 8'hFF : q[7:0];
      default:         r = c.rs;
    endcase
    return r;
  endfunction

  // Weighted mix toward the chosen operand, hard mix threshold
  function automatic logic [7:0] mix(logic [8:0] a, ch_t c);
    logic [16:0] sum;
    logic [7:0]  v;
    sum = 17'(a) * 17'(c.tow) + 17'(ALPHA_ONE - a) * 17'(c.raw);
    v = sum[15:8];
    if (c.pass) begin
      v = c.pass_val;
    end else if (c.hmix) begin
      v = v[7] ? 8'hFF : 8'h00;
    end
    return v;
  endfunction

endpackage

// ===== design/lbm_if.sv =====
interface lbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] mask_red;
  logic [7:0] mask_green;
  logic [7:0] mask_blue;
  logic [7:0] src_alpha;
  modport source (output valid, src_red, src_green, src_blue, mask_red, mask_green,
                  mask_blue, src_alpha, input ready);
  modport sink (input valid, src_red, src_green, src_blue, mask_red, mask_green,
                mask_blue, src_alpha, output ready);
endinterface

interface lbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

interface lbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/layer_blend_mode_unit.sv =====
// Channel   Dir  Handshake      Payload
// pix_in    in   valid/ready    src_red/green/blue, mask_red/green/blue, src_alpha
// pix_out   out  valid/ready    out_alpha, out_red, out_green, out_blue
// cfg       in   valid/ready    index (0 blend_mode, 1 mix_alpha), data
//
// Six register stages: operand setup, three radix-2 divider stages (three
// quotient bits each), mode result, mix into the output register.
// One item per cycle unless pix_out stalls; out valid rises as an item enters the
// output register. Each stage holds while the next is full and stalled, so bubbles
// collapse and a stall drops nothing. Synchronous active-high reset clears valids
// and registers (blend_mode 0, mix_alpha 0). cfg is always ready.
module layer_blend_mode_unit (
  input  logic      clk,
  input  logic      rst,
  lbm_in_if.sink    pix_in,
  lbm_out_if.source pix_out,
  lbm_cfg_if.sink   cfg
);

  logic [4:0] blend_mode;
  logic [8:0] mix_alpha;
  logic [8:0] a_eff;

  logic [5:0] vld;
  logic [5:0] en;

  lbm_pkg::st_t st [5];
  lbm_pkg::st_t nxt [5];
  logic [7:0] s_in [3];
  logic [7:0] m_in [3];

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= '0;
      mix_alpha <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lbm_pkg::REG_BLEND_MODE: blend_mode <= cfg.data[4:0];
        lbm_pkg::REG_MIX_ALPHA:  mix_alpha <= cfg.data;
        default: ;
      endcase
    end
  end

  assign a_eff = (mix_alpha > lbm_pkg::ALPHA_ONE) ? lbm_pkg::ALPHA_ONE : mix_alpha;

  // Stage enables: a stage loads when empty or when its item moves on
  always_comb begin
    en[5] = !vld[5] || pix_out.ready;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_in.ready = en[0];
  assign pix_out.valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Per-stage next values
  assign s_in[0] = pix_in.src_red;
  assign s_in[1] = pix_in.src_green;
  assign s_in[2] = pix_in.src_blue;
  assign m_in[0] = pix_in.mask_red;
  assign m_in[1] = pix_in.mask_green;
  assign m_in[2] = pix_in.mask_blue;

  always_comb begin
    nxt[0].alpha = pix_in.src_alpha;
    for (int c = 0; c < 3; c++) begin
      nxt[0].ch[c] = lbm_pkg::pre(blend_mode, s_in[c], m_in[c]);
    end
    for (int k = 1; k < 5; k++) begin
      nxt[k] = st[k-1];
    end
    for (int c = 0; c < 3; c++) begin
      nxt[1].ch[c] = lbm_pkg::div_init(st[0].ch[c]);
      nxt[2].ch[c] = lbm_pkg::div_step3(st[1].ch[c]);
      nxt[3].ch[c] = lbm_pkg::div_step3(st[2].ch[c]);
      nxt[4].ch[c].raw = lbm_pkg::raw_result(st[3].ch[c]);
    end
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      pix_out.out_alpha <= st[4].alpha;
      pix_out.out_red <= lbm_pkg::mix(a_eff, st[4].ch[0]);
      pix_out.out_green <= lbm_pkg::mix(a_eff, st[4].ch[1]);
      pix_out.out_blue <= lbm_pkg::mix(a_eff, st[4].ch[2]);
    end
  end

`ifndef SYNTH
  // An accepted item occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> vld[0])
    else $error("accepted item missing from first stage");

  // Input backpressure only when every stage is full
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (vld == 6'h3F))
    else $error("input stalled with an empty stage");

  // A waiting item in stage five survives an output stall
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !pix_out.ready && vld[4] |=> vld[4] && vld[5])
    else $error("item lost during output stall");
`endif

endmodule

// ===== tb/sv/layer_blend_mode_unit_tb.sv =====
`timescale 1ns / 1ps

module layer_blend_mode_unit_tb;

  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbm_in_if  pix_in ();
  lbm_out_if pix_out ();
  lbm_cfg_if cfg ();

  layer_blend_mode_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .pix_out (pix_out.source),
    .cfg     (cfg.sink)
  );

  always #2 clk = ~clk;

  // Shadow registers and the queue of expected output pixels
  logic [4:0] cur_mode;
  logic [8:0] cur_mix;
  pixel_t     pending_pixels[$];
  int         fail_count;
  int         cycle_count;
  int         stall_pct;

  // ---------------------------------------------------------------------------
  // Blend predictor
  // ---------------------------------------------------------------------------
  function automatic int imin(int x, int y);
    return x < y ? x : y;
  endfunction

  function automatic int imax(int x, int y);
    return x > y ? x : y;
  endfunction

  function automatic int iabs(int x);
    return x < 0 ? -x : x;
  endfunction

  function automatic int lean(int a, int toward, int r);
    return (a * toward + (256 - a) * r) / 256;
  endfunction

  // Mode value before the weighted mix
  function automatic int mode_value(logic [4:0] mode, int s, int m);
    int k;
    case (mode)
      lbm_pkg::MODE_LIGHTEN:     return imax(s, m);
      lbm_pkg::MODE_DARKEN:      return imin(s, m);
      lbm_pkg::MODE_MULTIPLY:    return m * s / 255;
      lbm_pkg::MODE_AVERAGE:     return (s + m) >> 1;
      lbm_pkg::MODE_ADD, lbm_pkg::MODE_LINEAR_DODGE:
        return imin(255, s + m);
      lbm_pkg::MODE_SUBTRACT, lbm_pkg::MODE_LINEAR_BURN:
        return (s + m < 255) ? 0 : s + m - 255;
      lbm_pkg::MODE_DIFFERENCE:  return iabs(s - m);
      lbm_pkg::MODE_NEGATION:    return 255 - iabs(255 - s - m);
      lbm_pkg::MODE_SCREEN:      return 255 - (((255 - s) * (255 - m)) >> 8);
      lbm_pkg::MODE_EXCLUSION:   return s + m - (2 * s * m) / 255;
      lbm_pkg::MODE_OVERLAY:
        return (m < 128) ? (2 * s * m / 255) : (255 - 2 * (255 - s) * (255 - m) / 255);
      lbm_pkg::MODE_SOFT_LIGHT: begin
        k = (m >> 1) + 64;
        if (s < 128) return (2 * k * s) / 255;
        return 255 - (2 * (255 - k) * (255 - s) + 254) / 255;
      end
      lbm_pkg::MODE_COLOR_DODGE:
        return (m == 255) ? 255 : imin(255, (s * 256) / (255 - m));
      lbm_pkg::MODE_COLOR_BURN:
        return (m == 0) ? 0 : imax(0, 255 - ((255 - s) * 256) / m);
      lbm_pkg::MODE_REFLECT:
        return (m == 255) ? 255 : imin(255, s * s / (255 - m));
      lbm_pkg::MODE_PHOENIX:     return 255 - iabs(s - m);
      lbm_pkg::MODE_DIVIDE:      return (m == 0) ? 255 : imin(255, s * 255 / m);
      default:                   return s;
    endcase
  endfunction

  // Linear, vivid and pin light: mask range split at 128
  function automatic int split_light(logic [4:0] lo_mode, logic [4:0] hi_mode,
                                     int s, int m, int a);
    int m2;
    if (m < 128) begin
      m2 = 2 * m;
      return lean(a, m2, mode_value(lo_mode, s, m2));
    end
    m2 = 2 * (m - 128);
    return lean(a, m2, mode_value(hi_mode, s, m2));
  endfunction

  function automatic logic [7:0] blend_channel(logic [4:0] mode, logic [8:0] mix,
                                               logic [7:0] src, logic [7:0] mask);
    int a;
    int s;
    int m;
    int v;
    a = (mix > lbm_pkg::ALPHA_ONE) ? 256 : int'(mix);
    s = int'(src);
    m = int'(mask);
    case (mode)
      lbm_pkg::MODE_NORMAL:
        v = (m == 0) ? s : (a * s + (256 - a) * m) / 256;
      lbm_pkg::MODE_HARD_LIGHT:
        v = lean(a, s, mode_value(lbm_pkg::MODE_OVERLAY, m, s));
      lbm_pkg::MODE_LINEAR_LIGHT:
        v = split_light(lbm_pkg::MODE_LINEAR_BURN, lbm_pkg::MODE_LINEAR_DODGE, s, m, a);
      lbm_pkg::MODE_VIVID_LIGHT:
        v = split_light(lbm_pkg::MODE_COLOR_BURN, lbm_pkg::MODE_COLOR_DODGE, s, m, a);
      lbm_pkg::MODE_PIN_LIGHT:
        v = split_light(lbm_pkg::MODE_DARKEN, lbm_pkg::MODE_LIGHTEN, s, m, a);
      lbm_pkg::MODE_HARD_MIX:
        v = (split_light(lbm_pkg::MODE_COLOR_BURN, lbm_pkg::MODE_COLOR_DODGE,
                         s, m, a) < 128) ? 0 : 255;
      lbm_pkg::MODE_GLOW:
        v = lean(a, s, mode_value(lbm_pkg::MODE_REFLECT, m, s));
      default:
        v = (mode > lbm_pkg::MODE_DIVIDE) ? s : lean(a, m, mode_value(mode, s, m));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Random byte, and a byte that is either end of the range
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] ext8();
    return 8'($urandom_range(0, 1) * 255);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Called at a falling edge; leaves valid high for the caller to drop
  task automatic write_reg(logic [7:0] idx, logic [8:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    if (idx == lbm_pkg::REG_BLEND_MODE) cur_mode = value[4:0];
    else if (idx == lbm_pkg::REG_MIX_ALPHA) cur_mix = value;
  endtask

  // Let the pipe empty before touching the registers
  task automatic drain;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_blend(logic [4:0] mode, logic [8:0] mix);
    drain();
    write_reg(lbm_pkg::REG_BLEND_MODE, 9'(mode));
    write_reg(lbm_pkg::REG_MIX_ALPHA, mix);
    cfg.valid <= 1'b0;
  endtask

  int burst_left = 0;

  // One pixel; called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                            logic [7:0] mr, logic [7:0] mg, logic [7:0] mb,
                            logic [7:0] al);
    pixel_t p;
    int     gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.src_red    <= sr;
    pix_in.src_green  <= sg;
    pix_in.src_blue   <= sb;
    pix_in.mask_red   <= mr;
    pix_in.mask_green <= mg;
    pix_in.mask_blue  <= mb;
    pix_in.src_alpha  <= al;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    p.alpha = al;
    p.red   = blend_channel(cur_mode, cur_mix, sr, mr);
    p.green = blend_channel(cur_mode, cur_mix, sg, mg);
    p.blue  = blend_channel(cur_mode, cur_mix, sb, mb);
    pending_pixels = {pending_pixels, p};
    @(negedge clk);
  endtask

  task automatic idle_input;
    pix_in.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic send_random_pixel;
    send_pixel(rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
  endtask

  // ---------------------------------------------------------------------------
  // Output check and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t exp_p;
    pixel_t got_p;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got_p = '{pix_out.out_alpha, pix_out.out_red, pix_out.out_green, pix_out.out_blue};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h", $realtime, got_p);
        fail_count++;
      end else begin
        exp_p = pending_pixels.pop_front();
        if (got_p.alpha !== exp_p.alpha) begin
          $display("%0t: out_alpha expected %0d actual %0d", $realtime, exp_p.alpha, got_p.alpha);
          fail_count++;
        end
        if (got_p.red !== exp_p.red) begin
          $display("%0t: out_red expected %0d actual %0d", $realtime, exp_p.red, got_p.red);
          fail_count++;
        end
        if (got_p.green !== exp_p.green) begin
          $display("%0t: out_green expected %0d actual %0d", $realtime, exp_p.green, got_p.green);
          fail_count++;
        end
        if (got_p.blue !== exp_p.blue) begin
          $display("%0t: out_blue expected %0d actual %0d", $realtime, exp_p.blue, got_p.blue);
          fail_count++;
        end
      end
    end
  end

  // Receiver ready: stretches of free flow, then phases of random stalls
  always @(negedge clk) begin
    if (cycle_count % 300 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
    pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults;
    // Normal mode at reset weight: mask zero and nonzero mask
    send_pixel(8'd200, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd0, 8'd255, 8'd17, 8'd255, 8'd1, 8'd0);
    idle_input();
  endtask

  // Extremes and a couple of mid values for every mode, weight ends
  task automatic test_every_mode;
    logic [8:0] mixes[4] = '{9'd0, 9'd256, 9'd511, 9'd128};
    for (int md = 0; md < 32; md++) begin
      set_blend(5'(md), mixes[md % 4]);
      send_pixel(8'd0, 8'd255, 8'd127, 8'd0, 8'd255, 8'd128, 8'hAA);
      send_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127, 8'h55);
      send_random_pixel();
      idle_input();
    end
  endtask

  // Random pixels over random settings, extremes weighted in
  task automatic test_random_pixels;
    logic [8:0] mix;
    for (int phase = 0; phase < 50; phase++) begin
      case ($urandom_range(0, 3))
        0: mix = 9'd0;
        1: mix = 9'd256;
        2: mix = 9'($urandom_range(257, 511));
        default: mix = 9'($urandom_range(0, 256));
      endcase
      set_blend(5'($urandom_range(0, 31)), mix);
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(0, 7) == 0)
          send_pixel(ext8(), rnd8(), ext8(), ext8(), ext8(), rnd8(), rnd8());
        else
          send_random_pixel();
      end
      idle_input();
    end
  endtask

  initial begin
    cur_mode     = lbm_pkg::MODE_NORMAL;
    cur_mix      = '0;
    fail_count   = 0;
    cycle_count  = 0;
    stall_pct    = 0;
    pix_in.valid = 1'b0;
    pix_in.src_red = '0;   pix_in.src_green = '0;  pix_in.src_blue = '0;
    pix_in.mask_red = '0;  pix_in.mask_green = '0; pix_in.mask_blue = '0;
    pix_in.src_alpha = '0;
    pix_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_every_mode();
    test_random_pixels();

    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY * 4) @(negedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
